FILE: design/bcpa_pkg.sv
`default_nettype none
package bcpa_pkg;

  localparam int NUM_PAGES = 2048;
  localparam int PAGE_W    = 11;
  localparam int ROWS      = 32;
  localparam int ROW_W     = 5;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int MAX_RUN   = 64;
  localparam int RUN_W     = 7;
  localparam int CNT_W     = 12;
  localparam int LINK_W    = 16;
  localparam int ATTR_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [PAGE_W-1:0] ZONE_FIRST_RST = 11'd1;
  localparam logic [PAGE_W-1:0] ZONE_LAST_RST  = 11'd1023;
  localparam logic [ATTR_W-1:0] REF_MASK_RST   = 16'd4;
  localparam logic [ATTR_W-1:0] SHR_MASK_RST   = 16'd256;
  localparam logic [CNT_W-1:0]  FREE_RST       = 12'd1023;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHR_MASK   = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [RUN_W-1:0]  page_count;
    logic [ATTR_W-1:0] page_attr;
    logic [PAGE_W-1:0] page_index;
  } bcpa_in_t;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] first_page;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [LINK_W-1:0] link_total;
  } bcpa_out_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd_word;
    logic scan;
    logic rd_page;
    logic wr_page;
    logic done;
    logic fail;
  } bcpa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic mode;
    logic past_top;
    logic hit;
    logic word_last;
    logic run_last;
  } bcpa_stat_t;

  function automatic logic [WORD_W-1:0] reset_row(input logic [ROW_W-1:0] row);
    logic [WORD_W-1:0] w;
    logic [PAGE_W-1:0] pg;
    for (int b = 0; b < WORD_W; b++) begin
      pg = {row, b[BIT_W-1:0]};
      w[b] = (pg < ZONE_FIRST_RST) || (pg > ZONE_LAST_RST);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/bitmap_contiguous_page_allocator_core.sv
// channel   signals                                           fires on
// request   start_i, busy_o, item_i                           start_i && !busy_o
// result    done_o, result_o                                  done_o, one cycle
// config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i cfg_valid_i && cfg_ready_o
// After reset a clearing pass over the 2048-entry attribute store holds busy_o high.
// An accepted request enters S_CHECK. One refused for length or free count goes on
// to S_DONE; a free reads and writes its page (S_FREE_RD, S_FREE_WR). An alloc reads
// 64-page bitmap words (S_RD_WORD) and looks at one page per scan step (S_SCAN) until
// a run fits or the pointer passes the zone end, then on success reads and writes each
// page of the run before S_DONE registers done_o. The receiver cannot stall.
`default_nettype none
module bitmap_contiguous_page_allocator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire bcpa_pkg::bcpa_in_t             item_i,
  output logic                                done_o,
  output bcpa_pkg::bcpa_out_t                 result_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bcpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bcpa_pkg::ATTR_W-1:0]    cfg_data_i
);
  import bcpa_pkg::*;

  bcpa_cmd_t  cmd;
  bcpa_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bcpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bcpa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .item_i     (item_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire

FILE: design/bcpa_datapath.sv
`default_nettype none
module bcpa_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bcpa_pkg::bcpa_cmd_t            cmd_i,
  output bcpa_pkg::bcpa_stat_t                stat_o,
  input  wire bcpa_pkg::bcpa_in_t             item_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [bcpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bcpa_pkg::ATTR_W-1:0]    cfg_data_i,
  output logic                                done_o,
  output bcpa_pkg::bcpa_out_t                 result_o
);
  import bcpa_pkg::*;

  logic [PAGE_W-1:0] zone_first_q, zone_last_q;
  logic [ATTR_W-1:0] ref_mask_q, shr_mask_q;
  logic [CNT_W-1:0]  free_q, free_d, used_q, used_d;
  logic [LINK_W-1:0] links_q, links_d;
  bcpa_in_t          item_q;
  logic [PAGE_W:0]   ptr_q;
  logic [RUN_W-1:0]  run_q, k_q;
  logic [PAGE_W-1:0] start_q, clr_q;
  logic              done_q;
  bcpa_out_t         res_q;

  logic [WORD_W-1:0] bm_mem [ROWS];
  logic [ROWS-1:0]   bm_vld_q;
  logic [WORD_W-1:0] bm_raw_q;
  logic              bm_rvld_q;
  logic [ROW_W-1:0]  bm_row_q;
  logic [WORD_W-1:0] bm_word, bm_wdata;

  logic [2*ATTR_W-1:0] am_mem [NUM_PAGES];
  logic [2*ATTR_W-1:0] am_rd_q;

  logic [PAGE_W-1:0] page;
  logic [ROW_W-1:0]  rd_row;
  logic [ATTR_W-1:0] a_rd, r_rd, a_new, r_new, special, r_dec;
  logic              bit_new;

  assign page    = item_q.mode ? item_q.page_index : start_q + {4'b0, k_q};
  assign rd_row  = cmd_i.rd_word ? ptr_q[PAGE_W-1:BIT_W] : page[PAGE_W-1:BIT_W];
  assign bm_word = bm_rvld_q ? bm_raw_q : reset_row(bm_row_q);
  assign a_rd    = am_rd_q[2*ATTR_W-1:ATTR_W];
  assign r_rd    = am_rd_q[ATTR_W-1:0];
  assign special = ref_mask_q | shr_mask_q;
  assign r_dec   = (r_rd != '0) ? r_rd - 16'd1 : '0;

  assign stat_o.clr_last  = (clr_q == PAGE_W'(NUM_PAGES - 1));
  assign stat_o.bad       = (item_q.page_count == '0) ||
                            (item_q.page_count > RUN_W'(MAX_RUN)) ||
                            (free_q < {5'b0, item_q.page_count});
  assign stat_o.mode      = item_q.mode;
  assign stat_o.past_top  = ptr_q > {1'b0, zone_last_q};
  assign stat_o.hit       = !bm_word[ptr_q[BIT_W-1:0]] && (run_q + 7'd1 == item_q.page_count);
  assign stat_o.word_last = (ptr_q[BIT_W-1:0] == '1);
  assign stat_o.run_last  = (k_q + 7'd1 == item_q.page_count);

  always_comb begin
    a_new   = a_rd;
    r_new   = r_rd;
    bit_new = bm_word[page[BIT_W-1:0]];
    free_d  = free_q;
    used_d  = used_q;
    links_d = links_q;
    if (!item_q.mode) begin
      if (a_rd == '0) begin
        bit_new = 1'b1;
        a_new   = item_q.page_attr;
        r_new   = (r_rd != '1) ? r_rd + 16'd1 : r_rd;
        used_d  = (used_q != '1) ? used_q + 12'd1 : used_q;
        free_d  = (free_q != '0) ? free_q - 12'd1 : '0;
        links_d = (links_q != '1) ? links_q + 16'd1 : links_q;
      end else if (((a_rd | item_q.page_attr) & special) != '0) begin
        a_new   = a_rd | item_q.page_attr;
        r_new   = (r_rd != '1) ? r_rd + 16'd1 : r_rd;
        links_d = (links_q != '1) ? links_q + 16'd1 : links_q;
      end else begin
        bit_new = 1'b1;
        a_new   = a_rd | item_q.page_attr;
      end
    end else if (a_rd != '0) begin
      links_d = (links_q != '0) ? links_q - 16'd1 : '0;
      if ((a_rd & special) != '0) begin
        r_new = r_dec;
        if (r_dec == '0) begin
          a_new  = '0;
          used_d = (used_q != '0) ? used_q - 12'd1 : '0;
          free_d = (free_q != '1) ? free_q + 12'd1 : free_q;
        end
      end else begin
        bit_new = 1'b0;
        a_new   = '0;
        r_new   = '0;
        used_d  = (used_q != '0) ? used_q - 12'd1 : '0;
        free_d  = (free_q != '1) ? free_q + 12'd1 : free_q;
      end
    end
    bm_wdata = bm_word;
    bm_wdata[page[BIT_W-1:0]] = bit_new;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_word || cmd_i.rd_page) begin
      bm_raw_q <= bm_mem[rd_row];
      bm_row_q <= rd_row;
    end
    if (cmd_i.wr_page) begin
      bm_mem[page[PAGE_W-1:BIT_W]] <= bm_wdata;
    end
    if (cmd_i.rd_page) begin
      am_rd_q <= am_mem[page];
    end
    if (cmd_i.clr_wr) begin
      am_mem[clr_q] <= '0;
    end else if (cmd_i.wr_page) begin
      am_mem[page] <= {a_new, r_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bm_vld_q  <= '0;
      bm_rvld_q <= 1'b0;
    end else begin
      if (cmd_i.rd_word || cmd_i.rd_page) begin
        bm_rvld_q <= bm_vld_q[rd_row];
      end
      if (cmd_i.wr_page) begin
        bm_vld_q[page[PAGE_W-1:BIT_W]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_first_q <= ZONE_FIRST_RST;
      zone_last_q  <= ZONE_LAST_RST;
      ref_mask_q   <= REF_MASK_RST;
      shr_mask_q   <= SHR_MASK_RST;
      free_q       <= FREE_RST;
      used_q       <= '0;
      links_q      <= '0;
      clr_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ZONE_FIRST: zone_first_q <= cfg_data_i[PAGE_W-1:0];
          CFG_ZONE_LAST:  zone_last_q  <= cfg_data_i[PAGE_W-1:0];
          CFG_REF_MASK:   ref_mask_q   <= cfg_data_i;
          CFG_SHR_MASK:   shr_mask_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 11'd1;
      end
      if (cmd_i.wr_page) begin
        free_q  <= free_d;
        used_q  <= used_d;
        links_q <= links_d;
      end
      done_q <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
      ptr_q  <= {1'b0, zone_first_q};
      run_q  <= '0;
      k_q    <= '0;
    end
    if (cmd_i.scan) begin
      ptr_q <= ptr_q + 12'd1;
      run_q <= bm_word[ptr_q[BIT_W-1:0]] ? '0 : run_q + 7'd1;
      if (stat_o.hit) begin
        start_q <= PAGE_W'(ptr_q - {5'b0, item_q.page_count} + 12'd1);
      end
    end
    if (cmd_i.wr_page) begin
      k_q <= k_q + 7'd1;
    end
    if (cmd_i.done) begin
      res_q.status     <= cmd_i.fail;
      res_q.first_page <= (cmd_i.fail || item_q.mode) ? '0 : start_q;
      res_q.free_pages <= free_q;
      res_q.used_pages <= used_q;
      res_q.link_total <= links_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

FILE: design/bcpa_ctrl.sv
`default_nettype none
module bcpa_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire bcpa_pkg::bcpa_stat_t stat_i,
  output bcpa_pkg::bcpa_cmd_t       cmd_o
);
  import bcpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_RD_WORD, S_SCAN,
    S_INIT_RD, S_INIT_WR, S_FREE_RD, S_FREE_WR, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   fail_q, fail_d;

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        fail_d = 1'b0;
        if (stat_i.mode) begin
          state_d = S_FREE_RD;
        end else if (stat_i.bad) begin
          fail_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_RD_WORD;
        end
      end
      S_RD_WORD: begin
        cmd_o.rd_word = 1'b1;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.past_top) begin
          fail_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.scan = 1'b1;
          if (stat_i.hit) state_d = S_INIT_RD;
          else if (stat_i.word_last) state_d = S_RD_WORD;
        end
      end
      S_INIT_RD: begin
        cmd_o.rd_page = 1'b1;
        state_d       = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd_o.wr_page = 1'b1;
        state_d       = stat_i.run_last ? S_DONE : S_INIT_RD;
      end
      S_FREE_RD: begin
        cmd_o.rd_page = 1'b1;
        state_d       = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd_o.wr_page = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        cmd_o.fail = fail_q;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fail_q  <= 1'b0;
      busy_o  <= 1'b1;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
      busy_o  <= (state_d != S_IDLE);
    end
  end

endmodule
`default_nettype wire

FILE: design/bcpa_checker.sv
`default_nettype none
module bcpa_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                done_o,
  input wire bcpa_pkg::bcpa_out_t result_o
);
  import bcpa_pkg::*;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised after start");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  a_fail_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status |-> result_o.first_page == '0)
    else $error("failed alloc reports a page");

endmodule

bind bitmap_contiguous_page_allocator_core bcpa_checker u_bcpa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .result_o(result_o)
);
`default_nettype wire
